/* src/dsp_pkg.sv */
// Types, codes and per-character parse functions for the date string parser.
// Used by dsp_core and date_string_parser; no dependencies.
package dsp_pkg;

	localparam int YEAR_W = 7;
	localparam int ACC_W  = 16;

	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_SLASH = 8'h2f;
	localparam logic [7:0] CH_DOT   = 8'h2e;
	localparam logic [7:0] CH_COLON = 8'h3a;

	localparam logic [ACC_W-1:0] MONTH_MAX = 16'd12;
	localparam logic [ACC_W-1:0] HOUR_MAX  = 16'd24;
	localparam logic [ACC_W-1:0] MIN_MAX   = 16'd59;
	localparam logic [ACC_W-1:0] YEAR_MAX  = 16'd99;
	localparam logic [ACC_W-1:0] YEAR_BASE = 16'd1900;
	localparam logic [ACC_W-1:0] ACC_SAT   = 16'hffff;

	localparam logic [3:0] ERR_NONE        = 4'd0;
	localparam logic [3:0] ERR_MONTH_EXP   = 4'd1;
	localparam logic [3:0] ERR_MONTH_ZERO  = 4'd2;
	localparam logic [3:0] ERR_MONTH_RANGE = 4'd3;
	localparam logic [3:0] ERR_SLASH       = 4'd4;
	localparam logic [3:0] ERR_DAY_EXP     = 4'd5;
	localparam logic [3:0] ERR_DAY_ZERO    = 4'd6;
	localparam logic [3:0] ERR_DAY_RANGE   = 4'd7;
	localparam logic [3:0] ERR_YEAR_EXP    = 4'd8;
	localparam logic [3:0] ERR_YEAR_RANGE  = 4'd9;
	localparam logic [3:0] ERR_HOUR_EXP    = 4'd10;
	localparam logic [3:0] ERR_HOUR_RANGE  = 4'd11;
	localparam logic [3:0] ERR_MIN_EXP     = 4'd12;
	localparam logic [3:0] ERR_MIN_RANGE   = 4'd13;
	localparam logic [3:0] ERR_MIN_24      = 4'd14;
	localparam logic [3:0] ERR_EXTRA       = 4'd15;

	typedef enum logic [2:0] {
		PH_MONTH,
		PH_DAY,
		PH_YEAR,
		PH_HOUR,
		PH_MIN,
		PH_DONE
	} phase_t;

	typedef struct packed {
		phase_t            phase;
		logic [ACC_W-1:0]  acc;
		logic              seen;
		logic [3:0]        month;
		logic [4:0]        day;
		logic [YEAR_W-1:0] year;
		logic              year_given;
		logic [4:0]        hour;
		logic [5:0]        minute;
		logic              time_given;
		logic [3:0]        err;
	} parse_t;

	typedef struct packed {
		logic [3:0]        status;
		logic [3:0]        month;
		logic [4:0]        day;
		logic [YEAR_W-1:0] year;
		logic              has_time;
		logic [4:0]        hour;
		logic [5:0]        minute;
	} res_t;

	localparam parse_t ST_START = parse_t'('0);

	function automatic logic [4:0] month_len(input logic [3:0] m);
		logic [4:0] len;
		case (m)
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
			4'd4, 4'd6, 4'd9, 4'd11:                     len = 5'd30;
			4'd2:                                        len = 5'd29;
			default:                                     len = 5'd0;
		endcase
		return len;
	endfunction

	function automatic logic [3:0] expected_err(input phase_t ph);
		logic [3:0] e;
		case (ph)
			PH_MONTH: e = ERR_MONTH_EXP;
			PH_DAY:   e = ERR_DAY_EXP;
			PH_YEAR:  e = ERR_YEAR_EXP;
			PH_HOUR:  e = ERR_HOUR_EXP;
			default:  e = ERR_MIN_EXP;
		endcase
		return e;
	endfunction

	function automatic parse_t advance(input parse_t s, input phase_t ph);
		parse_t r;
		r       = s;
		r.phase = ph;
		r.acc   = '0;
		r.seen  = 1'b0;
		return r;
	endfunction

	// Close the current field on a separator or at the end of the string.
	function automatic parse_t field_break(input parse_t s, input logic [7:0] c,
			input logic is_end);
		parse_t           r;
		logic [ACC_W-1:0] v;
		logic [ACC_W-1:0] vy;
		logic             is_slash;
		logic             is_dot;
		logic             is_colon;
		r        = s;
		v        = s.acc;
		vy       = (v > YEAR_BASE) ? v - YEAR_BASE : v;
		is_slash = !is_end && (c == CH_SLASH);
		is_dot   = !is_end && (c == CH_DOT);
		is_colon = !is_end && (c == CH_COLON);
		if (s.phase == PH_DONE) begin
			if (!is_end) r.err = ERR_EXTRA;
		end else if (!s.seen) begin
			r.err = expected_err(s.phase);
		end else begin
			case (s.phase)
				PH_MONTH: begin
					if (v == '0) r.err = ERR_MONTH_ZERO;
					else if (v > MONTH_MAX) r.err = ERR_MONTH_RANGE;
					else begin
						r.month = v[3:0];
						if (is_slash) r = advance(r, PH_DAY);
						else r.err = ERR_SLASH;
					end
				end
				PH_DAY: begin
					if (v == '0) r.err = ERR_DAY_ZERO;
					else if (v > {11'd0, month_len(s.month)}) r.err = ERR_DAY_RANGE;
					else begin
						r.day = v[4:0];
						if (is_end) r = advance(r, PH_DONE);
						else if (is_slash) r = advance(r, PH_YEAR);
						else if (is_dot) begin
							r            = advance(r, PH_HOUR);
							r.time_given = 1'b1;
						end else r.err = ERR_EXTRA;
					end
				end
				PH_YEAR: begin
					if (vy > YEAR_MAX) r.err = ERR_YEAR_RANGE;
					else begin
						r.year       = vy[YEAR_W-1:0];
						r.year_given = 1'b1;
						if (is_end) r = advance(r, PH_DONE);
						else if (is_dot) begin
							r            = advance(r, PH_HOUR);
							r.time_given = 1'b1;
						end else r.err = ERR_EXTRA;
					end
				end
				PH_HOUR: begin
					if (v > HOUR_MAX) r.err = ERR_HOUR_RANGE;
					else begin
						r.hour = v[4:0];
						if (is_end) r = advance(r, PH_DONE);
						else if (is_colon) r = advance(r, PH_MIN);
						else r.err = ERR_EXTRA;
					end
				end
				default: begin
					if (v > MIN_MAX) r.err = ERR_MIN_RANGE;
					else if (s.hour == HOUR_MAX[4:0] && v != '0) r.err = ERR_MIN_24;
					else begin
						r.minute = v[5:0];
						if (is_end) r = advance(r, PH_DONE);
						else r.err = ERR_EXTRA;
					end
				end
			endcase
		end
		return r;
	endfunction

endpackage

/* src/date_string_parser.sv */
// Top level of the date string parser: input register, result register, year register.
// Depends on dsp_pkg and dsp_core.

// Parses month/day[/year][.hours[:minutes]] strings fed one character per beat,
// with the final character flagged by last_char. Each character is taken into an
// input register and, when it leaves that register, folded into the parse state
// by one multiply-by-ten add and a set of range compares; one character per cycle
// is sustained while the result side does not stall. Exactly one result beat
// leaves per string, registered as its last character leaves the input register.
// A nonzero status carries the first error and zeroes the other fields. current_year
// resets to 0; the user must write it through the cfg port between strings, unchecked.
module date_string_parser import dsp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [7:0]        character,
	input  logic              last_char,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [3:0]        status,
	output logic [3:0]        month,
	output logic [4:0]        day,
	output logic [YEAR_W-1:0] year,
	output logic              has_time,
	output logic [4:0]        hour,
	output logic [5:0]        minute,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [YEAR_W-1:0] cfg_data
);

	logic              valid_s1;
	logic [7:0]        char_s1;
	logic              last_s1;
	logic              go_s1;
	logic [YEAR_W-1:0] cur_year_q;
	res_t              res;
	res_t              res_q;
	logic              out_valid_q;

	assign go_s1     = valid_s1 && !(last_s1 && out_valid_q && out_stall);
	assign in_stall  = valid_s1 && !go_s1;
	assign cfg_ready = 1'b1;

	dsp_core u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.beat_en      (go_s1),
		.character    (char_s1),
		.last_char    (last_s1),
		.current_year (cur_year_q),
		.result       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (go_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			char_s1 <= character;
			last_s1 <= last_char;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_year_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			cur_year_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (go_s1 && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go_s1 && last_s1) begin
			res_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = res_q.status;
	assign month     = res_q.month;
	assign day       = res_q.day;
	assign year      = res_q.year;
	assign has_time  = res_q.has_time;
	assign hour      = res_q.hour;
	assign minute    = res_q.minute;

`ifndef ASSERT_OFF
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.status != ERR_NONE |-> res_q.month == '0 && res_q.day == '0
			&& res_q.year == '0 && !res_q.has_time && res_q.hour == '0
			&& res_q.minute == '0)
		else $error("error result carries nonzero fields");

	a_no_time: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !res_q.has_time |-> res_q.hour == '0 && res_q.minute == '0)
		else $error("time fields set without a time part");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !go_s1 |=> valid_s1 && $stable(char_s1) && $stable(last_s1))
		else $error("held input beat lost");

	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(go_s1 && last_s1))
		else $error("result raised without a last character");
`endif

endmodule

/* src/dsp_core.sv */
// Parse state registers and the per-character update for the date string parser.
// Depends on dsp_pkg.
module dsp_core import dsp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              beat_en,
	input  logic [7:0]        character,
	input  logic              last_char,
	input  logic [YEAR_W-1:0] current_year,
	output res_t              result
);

	parse_t      st_q;
	parse_t      mid;
	parse_t      fin;
	parse_t      st_d;
	logic        is_digit;
	logic [19:0] acc_ext;
	logic [19:0] acc_new;

	assign is_digit = (character >= CH_ZERO) && (character <= CH_NINE);
	assign acc_ext  = {4'd0, st_q.acc};
	assign acc_new  = (acc_ext << 3) + (acc_ext << 1) + {16'd0, character[3:0]};

	always_comb begin
		mid = st_q;
		if (st_q.err == ERR_NONE) begin
			if (is_digit && st_q.phase != PH_DONE) begin
				mid.acc  = (|acc_new[19:16]) ? ACC_SAT : acc_new[15:0];
				mid.seen = 1'b1;
			end else begin
				mid = field_break(st_q, character, 1'b0);
			end
		end
		fin = mid;
		if (mid.err == ERR_NONE) fin = field_break(mid, character, 1'b1);
		st_d = last_char ? ST_START : mid;
	end

	always_comb begin
		result = '0;
		result.status = fin.err;
		if (fin.err == ERR_NONE) begin
			result.month    = fin.month;
			result.day      = fin.day;
			result.year     = fin.year_given ? fin.year : current_year;
			result.has_time = fin.time_given;
			result.hour     = fin.time_given ? fin.hour : 5'd0;
			result.minute   = fin.time_given ? fin.minute : 6'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_START;
		end else if (beat_en) begin
			st_q <= st_d;
		end
	end

endmodule
